FILE: design/imgnn_pkg.sv
// Shared constants for the nearest-neighbor image scaler: field widths, codes, register map.
package imgnn_pkg;

    // Stream field widths
    localparam int COORD_W   = 12;
    localparam int PIXEL_W   = 32;
    localparam int SRC_POS_W = 8;
    localparam int S_DATA_W  = 2 * COORD_W + PIXEL_W;
    localparam int M_DATA_W  = PIXEL_W + 2 * SRC_POS_W;

    // Request kinds carried on s_tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int SRC_SIZE_FW = 9;
    localparam int DST_SIZE_FW = 13;
    localparam int CHAN_FW     = 3;
    localparam int BYTES_PER_PIXEL = PIXEL_W / 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // Reset values of the size and channel registers
    localparam int RST_SRC_SIZE = 256;
    localparam int RST_DST_SIZE = 256;
    localparam int RST_CHANNELS = 3;

endpackage

FILE: design/imgnn_axis_map.sv
// One axis of the destination-to-source mapping: multiply, bit-per-stage divider, clamp.
module imgnn_axis_map #(
    parameter int SIZE_W = 9,
    parameter int DST_W  = 13,
    parameter int QW     = 9
) (
    input  logic              aclk,
    input  logic              adv,
    input  logic [DST_W-1:0]  dst,
    input  logic [SIZE_W-1:0] src_size,
    input  logic [DST_W-1:0]  dst_size,
    output logic [SIZE_W-1:0] src_pos
);

    localparam int NW = DST_W + QW + 1;
    localparam int PW = DST_W + SIZE_W;

    logic [PW-1:0] prod;
    logic [NW-1:0] n_calc;
    logic [NW-1:0] div2;
    logic [NW-1:0] rem_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [QW-1:0] q_lim;
    logic [QW-1:0] q_fin;

    // numerator 2*dst*S + D, divisor 2*D
    assign prod   = PW'(dst) * PW'(src_size);
    assign n_calc = NW'({prod, 1'b0}) + NW'(dst_size);
    assign div2   = NW'({dst_size, 1'b0});

    // restoring division, one quotient bit per stage, MSB first
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= n_calc;
            quo_reg[0] <= '0;
            for (int i = 0; i < QW; i++) begin
                if (rem_reg[i] >= (div2 << (QW - 1 - i))) begin
                    rem_reg[i+1] <= rem_reg[i] - (div2 << (QW - 1 - i));
                    quo_reg[i+1] <= {quo_reg[i][QW-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    quo_reg[i+1] <= {quo_reg[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // clamp to S-1
    assign q_fin   = quo_reg[QW];
    assign q_lim   = QW'(src_size) - QW'(1);
    assign src_pos = SIZE_W'((q_fin > q_lim) ? q_lim : q_fin);

endmodule

FILE: design/image_nearest_neighbor_resize.sv
// Top level of the nearest-neighbor image scaler around a single-port frame store.
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ------------------------------------------------
//  s_        in   s_tvalid / s_tready  s_tdata: col, row, pixel_in; s_tuser: req_type
//  m_        out  m_tvalid / m_tready  m_tdata: pixel_out, src_col, src_row;
//                                      m_tuser: range_error
//  cfg_      in   cfg_wr_en            cfg_addr selects the register, cfg_wr_data
//
// One transaction is taken every clock unless the skid register is full. A fetch result
// passes the per-axis divider (QW quotient bits, one stage per bit), the store read and output registers.
// Loads and fetches travel the same pipeline and touch the frame store in the same
// stage, so store accesses keep request order without forwarding.
// Reset (synchronous, aresetn low) empties the pipeline and loads the register defaults;
// the frame store itself is not cleared. A stalled m_ side is absorbed by a skid
// register, and s_tready drops only while that skid register is full.
module image_nearest_neighbor_resize
    import imgnn_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096,
    parameter int MAX_CHANNELS   = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [11:0] col, [23:12] row, [55:24] pixel_in
    input  logic                  s_tuser,   // [0] req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [31:0] pixel_out, [39:32] src_col,
                                             // [47:40] src_row
    output logic                  m_tuser,   // [0] range_error
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int TWW   = $clog2(MAX_DST_DIM + 1);
    localparam int QW    = (SWW > SHW) ? SWW : SHW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam int RST_SW = (RST_SRC_SIZE > MAX_SRC_WIDTH)  ? MAX_SRC_WIDTH  : RST_SRC_SIZE;
    localparam int RST_SH = (RST_SRC_SIZE > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : RST_SRC_SIZE;
    localparam int RST_TD = (RST_DST_SIZE > MAX_DST_DIM)    ? MAX_DST_DIM    : RST_DST_SIZE;
    localparam int RST_CH = (RST_CHANNELS > MAX_CHANNELS)   ? MAX_CHANNELS   : RST_CHANNELS;

    typedef struct packed {
        logic               fetch;
        logic               wr_en;
        logic               err;
        logic [PIXEL_W-1:0] pixel;
        logic [AW-1:0]      addr;
    } side_t;

    // zero acts as one, oversize saturates
    function automatic logic [31:0] sat_size(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        r = v;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // ---------------- configuration registers (held saturated) ----------------
    logic [SWW-1:0]             sw_reg;
    logic [SHW-1:0]             sh_reg;
    logic [TWW-1:0]             tw_reg;
    logic [TWW-1:0]             th_reg;
    logic [BYTES_PER_PIXEL-1:0] mask_reg;
    logic [BYTES_PER_PIXEL-1:0] mask_next;
    logic [BYTES_PER_PIXEL-1:0] mask_rst;
    logic [31:0]                chan_sat;

    always_comb begin
        chan_sat = sat_size(32'(cfg_wr_data[CHAN_FW-1:0]), 32'(MAX_CHANNELS));
        for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            mask_next[i] = (chan_sat > 32'(i));
            mask_rst[i]  = (RST_CH > i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= SWW'(RST_SW);
            sh_reg   <= SHW'(RST_SH);
            tw_reg   <= TWW'(RST_TD);
            th_reg   <= TWW'(RST_TD);
            mask_reg <= mask_rst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SOURCE_WIDTH: begin
                    sw_reg <= SWW'(sat_size(32'(cfg_wr_data[SRC_SIZE_FW-1:0]),
                                            32'(MAX_SRC_WIDTH)));
                end
                CFG_SOURCE_HEIGHT: begin
                    sh_reg <= SHW'(sat_size(32'(cfg_wr_data[SRC_SIZE_FW-1:0]),
                                            32'(MAX_SRC_HEIGHT)));
                end
                CFG_TARGET_WIDTH: begin
                    tw_reg <= TWW'(sat_size(32'(cfg_wr_data[DST_SIZE_FW-1:0]),
                                            32'(MAX_DST_DIM)));
                end
                CFG_TARGET_HEIGHT: begin
                    th_reg <= TWW'(sat_size(32'(cfg_wr_data[DST_SIZE_FW-1:0]),
                                            32'(MAX_DST_DIM)));
                end
                CFG_CHANNEL_COUNT: begin
                    mask_reg <= mask_next;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic skid_valid_reg;
    logic adv;

    // every stage moves together; only a full skid register holds them
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // ---------------- request decode ----------------
    logic [31:0] col_wide;
    logic [31:0] row_wide;
    logic [31:0] load_addr_wide;
    logic        in_fetch;
    side_t       side_in;

    assign col_wide       = 32'(s_tdata[COORD_W-1:0]);
    assign row_wide       = 32'(s_tdata[2*COORD_W-1:COORD_W]);
    assign in_fetch       = (s_tuser == REQ_FETCH);
    assign load_addr_wide = row_wide * 32'(MAX_SRC_WIDTH) + col_wide;

    always_comb begin
        side_in.fetch = in_fetch;
        // drop loads outside the source image
        side_in.wr_en = !in_fetch && (col_wide < 32'(sw_reg)) && (row_wide < 32'(sh_reg));
        // flag fetches outside the destination image
        side_in.err   = in_fetch && ((col_wide >= 32'(tw_reg)) || (row_wide >= 32'(th_reg)));
        side_in.pixel = s_tdata[S_DATA_W-1:2*COORD_W];
        side_in.addr  = load_addr_wide[AW-1:0];
    end

    // ---------------- per-axis mapping (QW + 1 stages) ----------------
    logic [SWW-1:0] sx;
    logic [SHW-1:0] sy;

    imgnn_axis_map #(
        .SIZE_W (SWW),
        .DST_W  (TWW),
        .QW     (QW)
    ) u_map_x (
        .aclk     (aclk),
        .adv      (adv),
        .dst      (col_wide[TWW-1:0]),
        .src_size (sw_reg),
        .dst_size (tw_reg),
        .src_pos  (sx)
    );

    imgnn_axis_map #(
        .SIZE_W (SHW),
        .DST_W  (TWW),
        .QW     (QW)
    ) u_map_y (
        .aclk     (aclk),
        .adv      (adv),
        .dst      (row_wide[TWW-1:0]),
        .src_size (sh_reg),
        .dst_size (th_reg),
        .src_pos  (sy)
    );

    // side band that tracks the mapping stages
    side_t       side_reg [QW+1];
    logic [QW:0] side_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int i = 0; i < QW; i++) begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_valid_reg <= '0;
        end else if (adv) begin
            side_valid_reg <= {side_valid_reg[QW-1:0], s_tvalid};
        end
    end

    // ---------------- frame store access ----------------
    side_t        m_side;
    logic         m_valid;
    logic [31:0]  fetch_addr_wide;
    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;
    logic [SWW-1:0]     r_sx_reg;
    logic [SHW-1:0]     r_sy_reg;
    logic               r_err_reg;
    logic               r_valid_reg;

    assign m_side          = side_reg[QW];
    assign m_valid         = side_valid_reg[QW];
    assign fetch_addr_wide = 32'(sy) * 32'(MAX_SRC_WIDTH) + 32'(sx);

    // one access a cycle: write for a kept load, read for a fetch
    always_ff @(posedge aclk) begin
        if (adv && m_valid && m_side.wr_en) begin
            mem[m_side.addr] <= m_side.pixel;
        end
        if (adv && m_valid && m_side.fetch) begin
            rdata_reg <= mem[fetch_addr_wide[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_sx_reg  <= sx;
            r_sy_reg  <= sy;
            r_err_reg <= m_side.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (adv) begin
            r_valid_reg <= m_valid && m_side.fetch;
        end
    end

    // ---------------- result formatting ----------------
    logic [PIXEL_W-1:0]  mask32;
    logic [31:0]         sx_wide;
    logic [31:0]         sy_wide;
    logic [M_DATA_W-1:0] res_data;
    logic                emit;

    always_comb begin
        for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            mask32[8*i +: 8] = {8{mask_reg[i]}};
        end
    end

    assign sx_wide = 32'(r_sx_reg);
    assign sy_wide = 32'(r_sy_reg);

    // out-of-range fetches return all-zero fields
    assign res_data = r_err_reg ? '0
                                : {sy_wide[SRC_POS_W-1:0], sx_wide[SRC_POS_W-1:0],
                                   rdata_reg & mask32};
    assign emit     = adv && r_valid_reg;

    // ---------------- output register and skid ----------------
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] skid_data_reg;
    logic                skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid once the held transaction is taken
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= emit;
        end else if (emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            if (emit) begin
                out_data_reg <= res_data;
                out_user_reg <= r_err_reg;
            end
        end else if (emit) begin
            skid_data_reg <= res_data;
            skid_user_reg <= r_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: tb/image_nearest_neighbor_resize_tb.sv
// Self-checking testbench for the nearest-neighbor image scaler: scoreboard class, drivers, stimulus.

localparam int SRC_W_MAX = 256;
localparam int SRC_H_MAX = 256;
localparam int DST_MAX   = 4096;
localparam int CHAN_MAX  = 4;
localparam int REPORT_CAP = 100;

typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  src_col;
    logic [7:0]  src_row;
    logic        range_error;
} scaled_pixel_t;

class resize_scoreboard;
    logic [31:0]   frame_copy [SRC_W_MAX*SRC_H_MAX];
    bit            loaded     [SRC_W_MAX*SRC_H_MAX];
    bit [8:0]      src_width_reg  = 9'd256;
    bit [8:0]      src_height_reg = 9'd256;
    bit [12:0]     dst_width_reg  = 13'd256;
    bit [12:0]     dst_height_reg = 13'd256;
    bit [2:0]      chan_reg       = 3'd3;
    scaled_pixel_t pending_q[$];
    int            errors;

    task report(string what);
        errors++;
        if (errors <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void set_register(logic [2:0] idx, int unsigned value);
        case (idx)
            imgnn_pkg::CFG_SOURCE_WIDTH:  src_width_reg  = value[8:0];
            imgnn_pkg::CFG_SOURCE_HEIGHT: src_height_reg = value[8:0];
            imgnn_pkg::CFG_TARGET_WIDTH:  dst_width_reg  = value[12:0];
            imgnn_pkg::CFG_TARGET_HEIGHT: dst_height_reg = value[12:0];
            imgnn_pkg::CFG_CHANNEL_COUNT: chan_reg       = value[2:0];
            default: ;
        endcase
    endfunction

    // zero acts as one, anything past the maximum saturates
    function int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned src_w();
        return clamp_size(src_width_reg, SRC_W_MAX);
    endfunction
    function int unsigned src_h();
        return clamp_size(src_height_reg, SRC_H_MAX);
    endfunction
    function int unsigned dst_w();
        return clamp_size(dst_width_reg, DST_MAX);
    endfunction
    function int unsigned dst_h();
        return clamp_size(dst_height_reg, DST_MAX);
    endfunction

    // round-half-up of dst*s/d in integers, clamped to the last source index
    function int unsigned map_axis(int unsigned dst, int unsigned s, int unsigned d);
        longint unsigned p;
        p = (2 * 64'(dst) * 64'(s) + 64'(d)) / (2 * 64'(d));
        return (p > s - 1) ? s - 1 : int'(p);
    endfunction

    function logic [31:0] chan_mask();
        int unsigned c;
        c = clamp_size(chan_reg, CHAN_MAX);
        if (c >= 4) return '1;
        return (32'd1 << (8 * c)) - 32'd1;
    endfunction

    // source position of an in-range fetch; 0 when the fetch lies outside the target
    function bit fetch_source(input logic [11:0] col, input logic [11:0] row,
                              output int unsigned sx, output int unsigned sy);
        sx = 0;
        sy = 0;
        if (col >= dst_w() || row >= dst_h()) return 0;
        sx = map_axis(col, src_w(), dst_w());
        sy = map_axis(row, src_h(), dst_h());
        return 1;
    endfunction

    function void note_request(logic req, logic [11:0] col, logic [11:0] row,
                               logic [31:0] pix);
        scaled_pixel_t want;
        int unsigned   sx, sy;
        if (req == imgnn_pkg::REQ_LOAD) begin
            if (col < src_w() && row < src_h()) begin
                frame_copy[row * SRC_W_MAX + col] = pix;
                loaded[row * SRC_W_MAX + col] = 1'b1;
            end
            return;
        end
        want = '0;
        if (fetch_source(col, row, sx, sy)) begin
            want.pixel   = frame_copy[sy * SRC_W_MAX + sx] & chan_mask();
            want.src_col = sx[7:0];
            want.src_row = sy[7:0];
        end else begin
            want.range_error = 1'b1;
        end
        pending_q.push_back(want);
    endfunction

    task check_result(logic [47:0] data, logic err);
        scaled_pixel_t want;
        if (pending_q.size() == 0) begin
            report($sformatf("result with nothing pending: tdata=%h tuser=%b", data, err));
            return;
        end
        want = pending_q.pop_front();
        if (data[31:0] !== want.pixel)
            report($sformatf("pixel_out %h, want %h", data[31:0], want.pixel));
        if (data[39:32] !== want.src_col)
            report($sformatf("src_col %0d, want %0d", data[39:32], want.src_col));
        if (data[47:40] !== want.src_row)
            report($sformatf("src_row %0d, want %0d", data[47:40], want.src_row));
        if (err !== want.range_error)
            report($sformatf("range_error %b, want %b", err, want.range_error));
    endtask
endclass

module image_nearest_neighbor_resize_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imgnn_pkg::*;

    // Cycles to let pass after the last result so that trailing loads leave the pipeline.
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 88;
    localparam int PHASES       = 12;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;   // [11:0] col, [23:12] row, [55:24] pixel_in
    logic                  s_tuser     = 1'b0; // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;            // [31:0] pixel_out, [39:32] src_col,
                                               // [47:40] src_row
    logic                  m_tuser;            // [0] range_error
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Percent of cycles in which the request side idles and the result side stalls.
    int unsigned src_idle_pct   = 36;
    int unsigned sink_stall_pct = 36;

    // Request transactions taken so far.
    int unsigned sent_count = 0;

    resize_scoreboard sb;

    image_nearest_neighbor_resize dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Result side: check every accepted transaction, then pick the next ready value.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one request transaction, idling first at random; hold it until it is taken.
    // Valid stays high on return so that back-to-back transactions need no extra step.
    task automatic send_request(input logic req, input logic [11:0] col,
                                input logic [11:0] row, input logic [31:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pix, row, col};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, col, row, pix);
        sent_count++;
    endtask

    // Fetch one destination pixel; load its source pixel first if it was never written,
    // since a read of an unwritten store entry is not defined.
    task automatic fetch_pixel(input logic [11:0] col, input logic [11:0] row);
        int unsigned sx, sy;
        if (sb.fetch_source(col, row, sx, sy) && !sb.loaded[sy * SRC_W_MAX + sx])
            send_request(REQ_LOAD, sx[11:0], sy[11:0], $urandom());
        send_request(REQ_FETCH, col, row, $urandom());
    endtask

    // Drop valid, wait for every pending result, then let trailing loads drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write transaction; the caller lowers the enable after the last one.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(input int unsigned sw, input int unsigned sh,
                                  input int unsigned tw, input int unsigned th,
                                  input int unsigned ch);
        wait_idle();
        write_register(CFG_SOURCE_WIDTH, sw);
        write_register(CFG_SOURCE_HEIGHT, sh);
        write_register(CFG_TARGET_WIDTH, tw);
        write_register(CFG_TARGET_HEIGHT, th);
        write_register(CFG_CHANNEL_COUNT, ch);
        cfg_wr_en <= 1'b0;
    endtask

    // Random settings, mostly small images with an occasional raw register extreme.
    task automatic random_settings();
        int unsigned sw, sh, tw, th;
        sw = ($urandom_range(3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 511);
        sh = ($urandom_range(3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 511);
        case ($urandom_range(4))
            0:       tw = $urandom_range(0, 8191);
            1:       tw = DST_MAX;
            default: tw = $urandom_range(1, 64);
        endcase
        case ($urandom_range(4))
            0:       th = $urandom_range(0, 8191);
            1:       th = DST_MAX;
            default: th = $urandom_range(1, 64);
        endcase
        apply_settings(sw, sh, tw, th, $urandom_range(0, 7));
    endtask

    // One phase of random traffic under the current settings.
    task automatic random_phase();
        int unsigned first;
        int unsigned pick;
        first = sent_count;
        // Video-style pass first: fill a small source image, then scan a small target raster.
        if (sb.src_w() * sb.src_h() <= 64) begin
            for (int unsigned r = 0; r < sb.src_h(); r++)
                for (int unsigned c = 0; c < sb.src_w(); c++) begin
                    send_request(REQ_LOAD, 12'(c), 12'(r), $urandom());
                end
        end
        if (sb.dst_w() * sb.dst_h() <= 64) begin
            for (int unsigned r = 0; r < sb.dst_h(); r++)
                for (int unsigned c = 0; c < sb.dst_w(); c++) begin
                    fetch_pixel(12'(c), 12'(r));
                end
        end
        while (sent_count - first < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                fetch_pixel(12'($urandom_range(0, sb.dst_w() - 1)),
                            12'($urandom_range(0, sb.dst_h() - 1)));
            end else if (pick < 55) begin
                // anywhere on the 12-bit grid, mostly outside the target
                fetch_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            end else if (pick < 88) begin
                send_request(REQ_LOAD, 12'($urandom_range(0, sb.src_w() - 1)),
                             12'($urandom_range(0, sb.src_h() - 1)), $urandom());
            end else begin
                // stray load, usually outside the source and ignored
                send_request(REQ_LOAD, 12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095)), $urandom());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: 256x256 source and target, three channels kept.
        send_request(REQ_LOAD, 12'd0, 12'd0, 32'hFFFF_FFFF);
        send_request(REQ_LOAD, 12'd255, 12'd255, 32'hA5A5_A5A5);
        send_request(REQ_LOAD, 12'd256, 12'd0, 32'h1111_1111);      // past source width
        send_request(REQ_LOAD, 12'd4095, 12'd4095, 32'h2222_2222);  // past both sizes
        fetch_pixel(12'd0, 12'd0);
        fetch_pixel(12'd255, 12'd255);
        fetch_pixel(12'd256, 12'd0);                                 // past target width
        fetch_pixel(12'd0, 12'd4095);                                // past target height

        // Single-pixel source blown up to the largest target, all four bytes kept.
        apply_settings(1, 1, DST_MAX, DST_MAX, 4);
        fetch_pixel(12'd4095, 12'd4095);                             // clamps to the last column
        send_request(REQ_LOAD, 12'd0, 12'd0, 32'h1234_5678);
        send_request(REQ_LOAD, 12'd1, 12'd0, 32'h8765_4321);         // outside a 1x1 source
        fetch_pixel(12'd2048, 12'd1024);

        // Zero sizes act as one, oversize registers saturate, zero channels keep one byte.
        apply_settings(0, 511, 0, 8191, 0);
        fetch_pixel(12'd0, 12'd4095);
        fetch_pixel(12'd1, 12'd0);
        send_request(REQ_LOAD, 12'd0, 12'd300, 32'hDEAD_BEEF);       // row past saturated height

        // Oversize width and channel count, tiny height.
        apply_settings(300, 7, 5000, 3, 7);
        fetch_pixel(12'd4095, 12'd2);
        fetch_pixel(12'd0, 12'd3);

        // Downscale with an exact half on the row axis (rounds up).
        apply_settings(7, 5, 3, 2, 2);
        fetch_pixel(12'd2, 12'd1);
        fetch_pixel(12'd1, 12'd0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       apply_settings(1, 1, 1, 1, 1);
                1:       apply_settings(SRC_W_MAX, SRC_H_MAX, DST_MAX, DST_MAX, 4);
                2:       apply_settings(SRC_W_MAX, 1, 1, DST_MAX, 2);
                3:       apply_settings(16, 16, 48, 40, 3);
                default: random_settings();
            endcase
            // hold both sides busy for one whole phase
            if (p == 3) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            random_phase();
            src_idle_pct   = 36;
            sink_stall_pct = 36;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("PASS image_nearest_neighbor_resize");
        else
            $display("FAIL image_nearest_neighbor_resize");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL image_nearest_neighbor_resize");
        $finish;
    end

endmodule
